### sv/uvsph_pkg.sv
// Package of types, constants and functions shared by the UV sphere point unit.
package uvsph_pkg;

  localparam int unsigned CNT_W = 11;
  localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;
  localparam int unsigned DIV_W = CNT_W + 1;
  localparam int unsigned PH_W = 32;
  localparam int unsigned QUO_W = PH_W + 1;
  localparam int unsigned TEX_W = 17;
  localparam int unsigned IDX_W = 21;
  localparam int unsigned POS_W = 16;
  localparam int unsigned ANG_W = 34;
  localparam int unsigned MUL_W = 32;
  localparam int unsigned DIV_CELLS = PH_W;
  localparam int unsigned SEC_TAP = 15;
  localparam int unsigned STK_TAP = 16;
  localparam int unsigned CFG_ADDR_W = 2;

  localparam int unsigned DEF_MAX_DIVISIONS = 1024;
  localparam int unsigned DEF_ANGLE_STAGES = 16;

  localparam logic [CNT_W-1:0] SECTOR_RESET = CNT_W'(36);
  localparam logic [CNT_W-1:0] STACK_RESET = CNT_W'(18);
  localparam logic [CFG_ADDR_W-1:0] REG_SECTOR_COUNT = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_STACK_COUNT = CFG_ADDR_W'(1);

  localparam logic [PH_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [PH_W-1:0] PI_Q30 = 32'hC90F_DAA2;
  localparam logic signed [ANG_W-1:0] GAIN_Q30 = 34'sh0_26DD_3B6A;
  localparam logic signed [63:0] RND_XY = 64'sh0000_1000_0000_0000;
  localparam logic signed [63:0] RND_Z = 64'sh0000_0000_0000_4000;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [TEX_W-1:0] tex;
  } div_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] x;
    logic signed [ANG_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } cor_t;

  typedef struct packed {
    logic valid;
    logic oog;
    logic [IDX_W-1:0] k1;
    logic [IDX_W-1:0] k2;
    logic up;
    logic lo;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic [1:0] q_sec;
    logic [1:0] q_stk;
  } side_t;

  function automatic logic signed [ANG_W-1:0] atan_q30(input int unsigned k);
    logic signed [ANG_W-1:0] a;
    case (k)
      0: a = 34'sh3243F6A8;
      1: a = 34'sh1DAC6705;
      2: a = 34'sh0FADBAFC;
      3: a = 34'sh07F56EA6;
      4: a = 34'sh03FEAB76;
      5: a = 34'sh01FFD55B;
      6: a = 34'sh00FFFAAA;
      7: a = 34'sh007FFF55;
      8: a = 34'sh003FFFEB;
      9: a = 34'sh001FFFFD;
      10: a = 34'sh00100000;
      11: a = 34'sh00080000;
      12: a = 34'sh00040000;
      13: a = 34'sh00020000;
      14: a = 34'sh00010000;
      15: a = 34'sh00008000;
      16: a = 34'sh00004000;
      17: a = 34'sh00002000;
      18: a = 34'sh00001000;
      19: a = 34'sh00000800;
      20: a = 34'sh00000400;
      21: a = 34'sh00000200;
      22: a = 34'sh00000100;
      23: a = 34'sh00000080;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic [POS_W-1:0] sat16(input logic signed [63:0] v);
    logic [POS_W-1:0] r;
    if (v > 64'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -64'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

### sv/uvsph_div_cell.sv
// One restoring-division cell: develops one quotient bit and may tap a rounded texture value.
module uvsph_div_cell #(
  parameter bit TEX_TAP = 1'b0
) (
  input  logic                           clk,
  input  logic [uvsph_pkg::DIV_W-1:0]    divisor,
  input  logic [uvsph_pkg::DIV_W-1:0]    half,
  input  uvsph_pkg::div_t                lane_in,
  output uvsph_pkg::div_t                lane_out
);

  logic [uvsph_pkg::DIV_W:0] rem2;
  logic                      ge;
  logic [uvsph_pkg::DIV_W-1:0] rem_next;
  logic [uvsph_pkg::QUO_W-1:0] quo_next;
  logic [uvsph_pkg::DIV_W:0]   rnd_sum;
  logic [uvsph_pkg::TEX_W-1:0] tex_next;

  always_comb begin
    rem2 = {lane_in.rem, 1'b0};
    ge = rem2 >= {1'b0, divisor};
    rem_next = ge ? uvsph_pkg::DIV_W'(rem2 - {1'b0, divisor}) : rem2[uvsph_pkg::DIV_W-1:0];
    quo_next = {lane_in.quo[uvsph_pkg::QUO_W-2:0], ge};
    rnd_sum = {1'b0, rem_next} + {1'b0, half};
    if (TEX_TAP) begin
      tex_next = quo_next[uvsph_pkg::TEX_W-1:0]
               + uvsph_pkg::TEX_W'(rnd_sum >= {1'b0, divisor});
    end else begin
      tex_next = lane_in.tex;
    end
  end

  always_ff @(posedge clk) begin
    lane_out.rem <= rem_next;
    lane_out.quo <= quo_next;
    lane_out.tex <= tex_next;
  end

endmodule

### sv/uvsph_cordic_cell.sv
// One rotation-mode CORDIC cell with a fixed shift and arctangent step.
module uvsph_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic            clk,
  input  uvsph_pkg::cor_t lane_in,
  output uvsph_pkg::cor_t lane_out
);

  logic signed [uvsph_pkg::ANG_W-1:0] x_in;
  logic signed [uvsph_pkg::ANG_W-1:0] y_in;
  logic signed [uvsph_pkg::ANG_W-1:0] z_in;
  logic signed [uvsph_pkg::ANG_W-1:0] dx;
  logic signed [uvsph_pkg::ANG_W-1:0] dy;
  logic signed [uvsph_pkg::ANG_W-1:0] ang;

  always_comb begin
    x_in = lane_in.x;
    y_in = lane_in.y;
    z_in = lane_in.z;
    dx = y_in >>> STAGE;
    dy = x_in >>> STAGE;
    ang = uvsph_pkg::atan_q30(STAGE);
  end

  always_ff @(posedge clk) begin
    if (z_in >= 0) begin
      lane_out.x <= x_in - dx;
      lane_out.y <= y_in + dy;
      lane_out.z <= z_in - ang;
    end else begin
      lane_out.x <= x_in + dx;
      lane_out.y <= y_in - dy;
      lane_out.z <= z_in + ang;
    end
  end

endmodule

### sv/uv_sphere_mesh_point_unit.sv
// Top level of the UV sphere point unit: division cells, CORDIC cells and output stages.
//
// Channel   Ports                                          Handshake
// input     stack_index, sector_index                      start && !busy
// result    pos_x/y/z, tex_u/v, indices, valids, flag      done, one cycle
// config    cfg_addr, cfg_wdata                            cfg_we
//
// An item is taken in every cycle in which busy is low.
// The pipeline holds a first division register, the 32 division cells, registers for the
// phase and the CORDIC start, the ANGLE_STAGES CORDIC cells and registers for the
// quadrant, the product and the output.
// Reset clears the registers to 36 sectors and 18 stacks and empties the pipeline.
// Busy is high during reset and for the first cycle after it; results cannot be held off.
module uv_sphere_mesh_point_unit #(
  parameter int unsigned MAX_DIVISIONS = uvsph_pkg::DEF_MAX_DIVISIONS,
  parameter int unsigned ANGLE_STAGES = uvsph_pkg::DEF_ANGLE_STAGES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [uvsph_pkg::CNT_W-1:0]         stack_index,
  input  logic [uvsph_pkg::CNT_W-1:0]         sector_index,
  input  logic                                cfg_we,
  input  logic [uvsph_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [uvsph_pkg::CNT_W-1:0]         cfg_wdata,
  output logic                                done,
  output logic signed [uvsph_pkg::POS_W-1:0]  pos_x,
  output logic signed [uvsph_pkg::POS_W-1:0]  pos_y,
  output logic signed [uvsph_pkg::POS_W-1:0]  pos_z,
  output logic [uvsph_pkg::TEX_W-1:0]         tex_u,
  output logic [uvsph_pkg::TEX_W-1:0]         tex_v,
  output logic [uvsph_pkg::IDX_W-1:0]         top_left_index,
  output logic [uvsph_pkg::IDX_W-1:0]         bottom_left_index,
  output logic                                upper_triangle_valid,
  output logic                                lower_triangle_valid,
  output logic                                out_of_grid
);

  localparam int unsigned MAX_EFF =
    (MAX_DIVISIONS > uvsph_pkg::CNT_MAX) ? uvsph_pkg::CNT_MAX : MAX_DIVISIONS;
  localparam logic [uvsph_pkg::CNT_W-1:0] MAX_CNT = uvsph_pkg::CNT_W'(MAX_EFF);
  localparam int unsigned NDC = uvsph_pkg::DIV_CELLS;
  localparam int unsigned PH_IDX = NDC + 1;
  localparam int unsigned Z_IDX = NDC + 2;
  localparam int unsigned COR_END = Z_IDX + ANGLE_STAGES;
  localparam int unsigned LAST = COR_END + 2;

  logic [uvsph_pkg::CNT_W-1:0] sector_reg;
  logic [uvsph_pkg::CNT_W-1:0] stack_reg;
  logic [uvsph_pkg::CNT_W-1:0] sc;
  logic [uvsph_pkg::CNT_W-1:0] tc;

  logic [uvsph_pkg::DIV_W-1:0] d_sec;
  logic [uvsph_pkg::DIV_W-1:0] h_sec;
  logic [uvsph_pkg::DIV_W-1:0] d_stk;
  logic [uvsph_pkg::DIV_W-1:0] h_stk;

  uvsph_pkg::side_t side [0:LAST];
  uvsph_pkg::side_t side_in;
  uvsph_pkg::side_t side_ph;
  uvsph_pkg::side_t side_z;
  uvsph_pkg::div_t  div_sec [0:NDC];
  uvsph_pkg::div_t  div_stk [0:NDC];
  uvsph_pkg::cor_t  cor_sec [0:ANGLE_STAGES];
  uvsph_pkg::cor_t  cor_stk [0:ANGLE_STAGES];

  logic [uvsph_pkg::DIV_W-1:0] n_sec;
  logic [uvsph_pkg::DIV_W-1:0] n_stk;
  logic [uvsph_pkg::DIV_W+uvsph_pkg::CNT_W-1:0] prod_k;

  logic [uvsph_pkg::PH_W-1:0] ph_sec;
  logic [uvsph_pkg::PH_W-1:0] ph_stk;
  logic [uvsph_pkg::PH_W-1:0] ph_sec_next;
  logic [uvsph_pkg::PH_W-1:0] ph_stk_next;
  logic [uvsph_pkg::DIV_W:0]  rs_sec;
  logic [uvsph_pkg::DIV_W:0]  rs_stk;

  logic [61:0] z_prod_sec;
  logic [61:0] z_prod_stk;

  logic signed [uvsph_pkg::ANG_W-1:0] c_sec_w;
  logic signed [uvsph_pkg::ANG_W-1:0] s_sec_w;
  logic signed [uvsph_pkg::ANG_W-1:0] c_stk_w;
  logic signed [uvsph_pkg::ANG_W-1:0] s_stk_w;
  logic signed [uvsph_pkg::MUL_W-1:0] cs;
  logic signed [uvsph_pkg::MUL_W-1:0] ss;
  logic signed [uvsph_pkg::MUL_W-1:0] ct;
  logic signed [uvsph_pkg::MUL_W-1:0] st;
  logic signed [63:0] px;
  logic signed [63:0] py;
  logic signed [63:0] pz;
  logic signed [63:0] rx;
  logic signed [63:0] ry;
  logic signed [63:0] rz;

  always_comb begin
    sc = sector_reg;
    if (sector_reg < uvsph_pkg::CNT_W'(3)) begin
      sc = uvsph_pkg::CNT_W'(3);
    end else if (sector_reg > MAX_CNT) begin
      sc = MAX_CNT;
    end
    tc = stack_reg;
    if (stack_reg < uvsph_pkg::CNT_W'(2)) begin
      tc = uvsph_pkg::CNT_W'(2);
    end else if (stack_reg > MAX_CNT) begin
      tc = MAX_CNT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_reg <= uvsph_pkg::SECTOR_RESET;
      stack_reg <= uvsph_pkg::STACK_RESET;
      busy <= 1'b1;
    end else begin
      if (cfg_we && cfg_addr == uvsph_pkg::REG_SECTOR_COUNT) begin
        sector_reg <= cfg_wdata;
      end
      if (cfg_we && cfg_addr == uvsph_pkg::REG_STACK_COUNT) begin
        stack_reg <= cfg_wdata;
      end
      busy <= 1'b0;
    end
  end

  assign d_sec = {1'b0, sc};
  assign h_sec = {2'b0, sc[uvsph_pkg::CNT_W-1:1]};
  assign d_stk = {tc, 1'b0};
  assign h_stk = {1'b0, tc[uvsph_pkg::CNT_W-1:1], 1'b0};

  always_comb begin
    n_sec = {1'b0, sector_index};
    n_stk = {1'b0, stack_index};
    prod_k = stack_index * (uvsph_pkg::DIV_W'(sc) + uvsph_pkg::DIV_W'(1));
    side_in = '0;
    side_in.valid = start && !busy;
    side_in.oog = (stack_index > tc) || (sector_index > sc);
    side_in.k1 = uvsph_pkg::IDX_W'(prod_k) + uvsph_pkg::IDX_W'(sector_index);
    side_in.k2 = side_in.k1 + uvsph_pkg::IDX_W'(sc) + uvsph_pkg::IDX_W'(1);
    side_in.up = (stack_index < tc) && (sector_index < sc) && (stack_index != '0);
    side_in.lo = (stack_index < tc) && (sector_index < sc)
              && ((stack_index + uvsph_pkg::CNT_W'(1)) != tc);
  end

  always_ff @(posedge clk) begin
    div_sec[0].quo <= uvsph_pkg::QUO_W'(n_sec >= d_sec);
    div_stk[0].quo <= uvsph_pkg::QUO_W'(n_stk >= d_stk);
    div_sec[0].tex <= '0;
    div_stk[0].tex <= '0;
    div_sec[0].rem <= (n_sec >= d_sec) ? n_sec - d_sec : n_sec;
    div_stk[0].rem <= (n_stk >= d_stk) ? n_stk - d_stk : n_stk;
  end

  for (genvar c = 0; c < NDC; c++) begin : g_div
    uvsph_div_cell #(.TEX_TAP(c == uvsph_pkg::SEC_TAP)) u_sec (
      .clk(clk), .divisor(d_sec), .half(h_sec),
      .lane_in(div_sec[c]), .lane_out(div_sec[c+1])
    );
    uvsph_div_cell #(.TEX_TAP(c == uvsph_pkg::STK_TAP)) u_stk (
      .clk(clk), .divisor(d_stk), .half(h_stk),
      .lane_in(div_stk[c]), .lane_out(div_stk[c+1])
    );
  end

  always_comb begin
    side_ph = side[PH_IDX-1];
    side_ph.tex_u = div_sec[NDC].tex;
    side_ph.tex_v = div_stk[NDC].tex;
    side_z = side[Z_IDX-1];
    side_z.q_sec = ph_sec[uvsph_pkg::PH_W-1 -: 2];
    side_z.q_stk = ph_stk[uvsph_pkg::PH_W-1 -: 2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n <= LAST; n++) begin
        side[n].valid <= 1'b0;
      end
    end else begin
      side[0] <= side_in;
      for (int n = 1; n <= LAST; n++) begin
        if (n == PH_IDX) begin
          side[n] <= side_ph;
        end else if (n == Z_IDX) begin
          side[n] <= side_z;
        end else begin
          side[n] <= side[n-1];
        end
      end
    end
  end

  always_comb begin
    rs_sec = {1'b0, div_sec[NDC].rem} + {1'b0, h_sec};
    rs_stk = {1'b0, div_stk[NDC].rem} + {1'b0, h_stk};
    ph_sec_next = div_sec[NDC].quo[uvsph_pkg::PH_W-1:0]
                + uvsph_pkg::PH_W'(rs_sec >= {1'b0, d_sec});
    ph_stk_next = uvsph_pkg::QUARTER_TURN
                - (div_stk[NDC].quo[uvsph_pkg::PH_W-1:0]
                + uvsph_pkg::PH_W'(rs_stk >= {1'b0, d_stk}));
    z_prod_sec = ph_sec[29:0] * uvsph_pkg::PI_Q30;
    z_prod_stk = ph_stk[29:0] * uvsph_pkg::PI_Q30;
  end

  always_ff @(posedge clk) begin
    ph_sec <= ph_sec_next;
    ph_stk <= ph_stk_next;
    cor_sec[0].x <= uvsph_pkg::GAIN_Q30;
    cor_sec[0].y <= '0;
    cor_sec[0].z <= {3'b0, z_prod_sec[61:31]};
    cor_stk[0].x <= uvsph_pkg::GAIN_Q30;
    cor_stk[0].y <= '0;
    cor_stk[0].z <= {3'b0, z_prod_stk[61:31]};
  end

  for (genvar k = 0; k < ANGLE_STAGES; k++) begin : g_cor
    uvsph_cordic_cell #(.STAGE(k)) u_sec (
      .clk(clk), .lane_in(cor_sec[k]), .lane_out(cor_sec[k+1])
    );
    uvsph_cordic_cell #(.STAGE(k)) u_stk (
      .clk(clk), .lane_in(cor_stk[k]), .lane_out(cor_stk[k+1])
    );
  end

  always_comb begin
    unique case (side[COR_END].q_sec)
      uvsph_pkg::QUAD_0: begin
        c_sec_w = cor_sec[ANGLE_STAGES].x;
        s_sec_w = cor_sec[ANGLE_STAGES].y;
      end
      uvsph_pkg::QUAD_1: begin
        c_sec_w = -cor_sec[ANGLE_STAGES].y;
        s_sec_w = cor_sec[ANGLE_STAGES].x;
      end
      uvsph_pkg::QUAD_2: begin
        c_sec_w = -cor_sec[ANGLE_STAGES].x;
        s_sec_w = -cor_sec[ANGLE_STAGES].y;
      end
      default: begin
        c_sec_w = cor_sec[ANGLE_STAGES].y;
        s_sec_w = -cor_sec[ANGLE_STAGES].x;
      end
    endcase
    unique case (side[COR_END].q_stk)
      uvsph_pkg::QUAD_0: begin
        c_stk_w = cor_stk[ANGLE_STAGES].x;
        s_stk_w = cor_stk[ANGLE_STAGES].y;
      end
      uvsph_pkg::QUAD_1: begin
        c_stk_w = -cor_stk[ANGLE_STAGES].y;
        s_stk_w = cor_stk[ANGLE_STAGES].x;
      end
      uvsph_pkg::QUAD_2: begin
        c_stk_w = -cor_stk[ANGLE_STAGES].x;
        s_stk_w = -cor_stk[ANGLE_STAGES].y;
      end
      default: begin
        c_stk_w = cor_stk[ANGLE_STAGES].y;
        s_stk_w = -cor_stk[ANGLE_STAGES].x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cs <= c_sec_w[uvsph_pkg::MUL_W-1:0];
    ss <= s_sec_w[uvsph_pkg::MUL_W-1:0];
    ct <= c_stk_w[uvsph_pkg::MUL_W-1:0];
    st <= s_stk_w[uvsph_pkg::MUL_W-1:0];
    px <= ct * cs;
    py <= ct * ss;
    pz <= 64'(st);
  end

  always_comb begin
    rx = (px + uvsph_pkg::RND_XY) >>> 45;
    ry = (py + uvsph_pkg::RND_XY) >>> 45;
    rz = (pz + uvsph_pkg::RND_Z) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side[LAST].valid;
    end
    if (side[LAST].oog) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
      tex_u <= '0;
      tex_v <= '0;
      top_left_index <= '0;
      bottom_left_index <= '0;
      upper_triangle_valid <= 1'b0;
      lower_triangle_valid <= 1'b0;
      out_of_grid <= 1'b1;
    end else begin
      pos_x <= uvsph_pkg::sat16(rx);
      pos_y <= uvsph_pkg::sat16(ry);
      pos_z <= uvsph_pkg::sat16(rz);
      tex_u <= side[LAST].tex_u;
      tex_v <= side[LAST].tex_v;
      top_left_index <= side[LAST].k1;
      bottom_left_index <= side[LAST].k2;
      upper_triangle_valid <= side[LAST].up;
      lower_triangle_valid <= side[LAST].lo;
      out_of_grid <= 1'b0;
    end
  end

endmodule

### sv/uvsph_checker.sv
// Port-level checks of the UV sphere point unit and their attachment to it.
module uvsph_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                busy,
  input logic                                done,
  input logic signed [uvsph_pkg::POS_W-1:0]  pos_x,
  input logic signed [uvsph_pkg::POS_W-1:0]  pos_y,
  input logic signed [uvsph_pkg::POS_W-1:0]  pos_z,
  input logic [uvsph_pkg::TEX_W-1:0]         tex_u,
  input logic [uvsph_pkg::TEX_W-1:0]         tex_v,
  input logic [uvsph_pkg::IDX_W-1:0]         top_left_index,
  input logic [uvsph_pkg::IDX_W-1:0]         bottom_left_index,
  input logic                                upper_triangle_valid,
  input logic                                lower_triangle_valid,
  input logic                                out_of_grid
);

  a_busy_only_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) || !busy) else $error("busy high outside reset recovery");

  a_oog_zero: assert property (@(posedge clk) disable iff (rst)
    (done && out_of_grid) |-> (pos_x == '0 && pos_y == '0 && pos_z == '0
      && tex_u == '0 && tex_v == '0 && top_left_index == '0
      && bottom_left_index == '0)) else $error("out-of-grid item has nonzero fields");

  a_tri_in_grid: assert property (@(posedge clk) disable iff (rst)
    (done && (upper_triangle_valid || lower_triangle_valid)) |-> !out_of_grid)
    else $error("triangle flagged for an out-of-grid item");

  a_tex_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (tex_u <= 17'd65536 && tex_v <= 17'd65536))
    else $error("texture coordinate above one");

  a_rows_differ: assert property (@(posedge clk) disable iff (rst)
    (done && !out_of_grid) |-> (bottom_left_index != top_left_index))
    else $error("bottom-left index equals top-left index");

endmodule

bind uv_sphere_mesh_point_unit uvsph_checker u_uvsph_checker (.*);

### tb/testbench.sv
// Self-checking testbench for the UV sphere point unit with its own point predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CNT_W = uvsph_pkg::CNT_W;
  localparam int unsigned CNT_MAX = uvsph_pkg::CNT_MAX;
  localparam int unsigned POS_W = uvsph_pkg::POS_W;
  localparam int unsigned TEX_W = uvsph_pkg::TEX_W;
  localparam int unsigned IDX_W = uvsph_pkg::IDX_W;
  localparam int unsigned CFG_ADDR_W = uvsph_pkg::CFG_ADDR_W;
  localparam int unsigned DEF_ANGLE_STAGES = uvsph_pkg::DEF_ANGLE_STAGES;
  localparam int unsigned DEF_MAX_DIVISIONS = uvsph_pkg::DEF_MAX_DIVISIONS;
  localparam logic [CFG_ADDR_W-1:0] REG_SECTOR_COUNT = uvsph_pkg::REG_SECTOR_COUNT;
  localparam logic [CFG_ADDR_W-1:0] REG_STACK_COUNT = uvsph_pkg::REG_STACK_COUNT;
  localparam logic [1:0] QUAD_0 = uvsph_pkg::QUAD_0;
  localparam logic [1:0] QUAD_1 = uvsph_pkg::QUAD_1;
  localparam logic [1:0] QUAD_2 = uvsph_pkg::QUAD_2;

  localparam int unsigned LATENCY = DEF_ANGLE_STAGES + 38;
  localparam int unsigned DRAIN = LATENCY + 20;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = CFG_ADDR_W'(3);

  typedef struct packed {
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
  } grid_point_t;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic [TEX_W-1:0] u;
    logic [TEX_W-1:0] v;
    logic [IDX_W-1:0] k1;
    logic [IDX_W-1:0] k2;
    logic up;
    logic lo;
    logic oog;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [CNT_W-1:0] stack_index = '0;
  logic [CNT_W-1:0] sector_index = '0;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic done;
  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
  logic [TEX_W-1:0] tex_u, tex_v;
  logic [IDX_W-1:0] top_left_index, bottom_left_index;
  logic upper_triangle_valid, lower_triangle_valid, out_of_grid;

  grid_point_t pending_points[$];
  vertex_t expected_vertices[$];
  logic [CNT_W-1:0] sector_reg = uvsph_pkg::SECTOR_RESET;
  logic [CNT_W-1:0] stack_reg = uvsph_pkg::STACK_RESET;
  int gap_left = 0;
  int gap_max = 6;
  int mismatches = 0;
  int cycles = 0;

  longint atan_tab[16] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEB, 64'h001FFFFD, 64'h00100000, 64'h00080000,
    64'h00040000, 64'h00020000, 64'h00010000, 64'h00008000
  };

  uv_sphere_mesh_point_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .stack_index(stack_index), .sector_index(sector_index),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .done(done), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .tex_u(tex_u), .tex_v(tex_v),
    .top_left_index(top_left_index), .bottom_left_index(bottom_left_index),
    .upper_triangle_valid(upper_triangle_valid),
    .lower_triangle_valid(lower_triangle_valid), .out_of_grid(out_of_grid)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned clamp_count(logic [CNT_W-1:0] v, int unsigned lo);
    if (v < lo) return lo;
    if (v > DEF_MAX_DIVISIONS) return DEF_MAX_DIVISIONS;
    return v;
  endfunction

  function automatic logic signed [POS_W-1:0] saturate(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[POS_W-1:0];
  endfunction

  // Rotation-mode CORDIC on a turn phase; cosine and sine come back in Q2.30.
  function automatic void sin_cos(input logic [31:0] phase, output longint c,
                                  output longint s);
    longint unsigned r;
    longint x, y, z, dx, dy;
    r = phase[29:0];
    z = longint'((r * 64'hC90FDAA2) >> 31);
    x = 64'h26DD3B6A;
    y = 0;
    for (int k = 0; k < DEF_ANGLE_STAGES; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[k];
      end else begin
        x += dx; y -= dy; z += atan_tab[k];
      end
    end
    case (phase[31:30])
      QUAD_0: begin c = x; s = y; end
      QUAD_1: begin c = -y; s = x; end
      QUAD_2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic vertex_t predict_vertex(grid_point_t p);
    vertex_t r;
    longint unsigned sc, tc, i, j, q;
    logic [31:0] ph_sec, ph_stk;
    longint cs, ss, ct, st;
    sc = clamp_count(sector_reg, 3);
    tc = clamp_count(stack_reg, 2);
    i = p.row;
    j = p.col;
    r = '0;
    if (i > tc || j > sc) begin
      r.oog = 1'b1;
      return r;
    end
    ph_sec = 32'(((j << 32) + sc / 2) / sc);
    q = ((i << 31) + tc / 2) / tc;
    ph_stk = 32'(64'h40000000 - q);
    sin_cos(ph_sec, cs, ss);
    sin_cos(ph_stk, ct, st);
    r.px = saturate((ct * cs + (64'sd1 <<< 44)) >>> 45);
    r.py = saturate((ct * ss + (64'sd1 <<< 44)) >>> 45);
    r.pz = saturate((st + (64'sd1 <<< 14)) >>> 15);
    r.u = TEX_W'((j * 65536 + sc / 2) / sc);
    r.v = TEX_W'((i * 65536 + tc / 2) / tc);
    r.k1 = IDX_W'(i * (sc + 1) + j);
    r.k2 = IDX_W'(i * (sc + 1) + j + sc + 1);
    r.up = (i < tc) && (j < sc) && (i != 0);
    r.lo = (i < tc) && (j < sc) && (i + 1 != tc);
    return r;
  endfunction

  // Driver: one item per handshake, with a random gap drawn after each item.
  always @(posedge clk) begin
    logic next_start;
    grid_point_t p;
    grid_point_t acc;
    if (rst) begin
      start <= 1'b0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        acc.row = stack_index;
        acc.col = sector_index;
        expected_vertices = {expected_vertices, predict_vertex(acc)};
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_points.size() > 0) begin
          p = pending_points.pop_front();
          stack_index <= p.row;
          sector_index <= p.col;
          next_start = 1'b1;
          gap_left <= (gap_max == 0) ? 0 : int'($urandom_range(0, gap_max));
        end
      end
      start <= next_start;
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    vertex_t got, want;
    if (!rst && done) begin
      got = '{pos_x, pos_y, pos_z, tex_u, tex_v, top_left_index, bottom_left_index,
              upper_triangle_valid, lower_triangle_valid, out_of_grid};
      if (expected_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
      end else begin
        want = expected_vertices.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= CNT_W'(val);
    if (addr == REG_SECTOR_COUNT) sector_reg = CNT_W'(val);
    else if (addr == REG_STACK_COUNT) stack_reg = CNT_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_points.size() > 0 || start || expected_vertices.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic add_point(int unsigned i, int unsigned j);
    grid_point_t p;
    p.row = CNT_W'(i);
    p.col = CNT_W'(j);
    pending_points = {pending_points, p};
  endtask

  // Edges of the current grid, then mostly valid points with some noise.
  task automatic run_phase(int unsigned n);
    int unsigned sc, tc;
    sc = 32'(clamp_count(sector_reg, 3));
    tc = 32'(clamp_count(stack_reg, 2));
    gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
    add_point(0, 0);
    add_point(tc, sc);
    add_point(tc - 1, sc - 1);
    add_point(tc + 1, 0);
    add_point(0, sc + 1);
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 8) add_point($urandom_range(0, tc), $urandom_range(0, sc));
      else add_point($urandom_range(0, CNT_MAX), $urandom_range(0, CNT_MAX));
    end
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    add_point(0, 0);
    add_point(0, 36);
    add_point(18, 0);
    add_point(18, 36);
    add_point(17, 35);
    add_point(17, 36);
    add_point(18, 35);
    add_point(1, 0);
    add_point(9, 9);
    add_point(9, 18);
    add_point(9, 27);
    add_point(19, 0);
    add_point(0, 37);
    add_point(CNT_MAX, CNT_MAX);
    add_point(1024, 1024);
    add_point(12'h555, 12'h2AA);
    add_point(12'h2AA, 12'h555);
    wait_idle();
    run_phase(150);
    write_reg(REG_SECTOR_COUNT, 3);
    write_reg(REG_STACK_COUNT, 2);
    run_phase(150);
    write_reg(REG_SECTOR_COUNT, 1024);
    write_reg(REG_STACK_COUNT, 1024);
    run_phase(250);
    write_reg(REG_SECTOR_COUNT, 0);
    write_reg(REG_STACK_COUNT, 0);
    run_phase(150);
    write_reg(REG_SECTOR_COUNT, CNT_MAX);
    write_reg(REG_STACK_COUNT, CNT_MAX);
    run_phase(200);
    write_reg(REG_SECTOR_COUNT, 7);
    write_reg(REG_STACK_COUNT, 5);
    write_reg(REG_SPARE_2, CNT_MAX);
    write_reg(REG_SPARE_3, 0);
    run_phase(150);
    write_reg(REG_SECTOR_COUNT, 1025);
    write_reg(REG_STACK_COUNT, 1);
    run_phase(150);
    for (int k = 0; k < 3; k++) begin
      write_reg(REG_SECTOR_COUNT, $urandom_range(3, 1024));
      write_reg(REG_STACK_COUNT, $urandom_range(2, 1024));
      run_phase(140);
    end
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
sv/uvsph_pkg.sv
sv/uvsph_div_cell.sv
sv/uvsph_cordic_cell.sv
sv/uv_sphere_mesh_point_unit.sv
sv/uvsph_checker.sv
tb/testbench.sv
